// ----- hw/rtl/wad_pkg.sv -----
// Package for the weighted average decimator: widths, register indexes, types.
// No dependencies.
package wad_pkg;
   localparam int CHANNELS    = 3;
   localparam int MAX_STEP    = 4096;
   localparam int VAL_W       = 32;
   localparam int TS_W        = 63;
   localparam int SUM_W       = 64;
   localparam int STEP_W      = 13;
   localparam int DEN_W       = 25;
   localparam int CNT_W       = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_IDX_W-1:0] REG_STEP   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE = 1'd1;

   // per-lane control from the sequencer
   typedef struct packed {
      logic             acc;      // add value*k
      logic             clr;      // clear sum
      logic             div_start;
      logic             div_step; // one divider step this cycle
      logic [DEN_W-1:0] den;
   } lane_ctl_type;
endpackage

// ----- hw/rtl/weighted_average_decimator_top.sv -----
// Weighted average decimator: three lanes accumulate value*k and divide in parallel.
// Each sample is accumulated in S_ACC; one that closes a window then passes S_DEN
// (divider load), 64 divider steps in S_DIV and the output register. Samples are
// taken only in S_IDLE, after the last is through; a close also waits on the output.
// Reset (synchronous) clears sums and position; step 1 and all channels enabled.
// Depends on wad_pkg and wad_lane.
module weighted_average_decimator_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [wad_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wad_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // chan_a_value[31:0], chan_b_value[63:32], chan_c_value[95:64], timestamp[158:96]
   input  logic [159:0]                       req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // avg_a[31:0], avg_b[63:32], avg_c[95:64], out_timestamp[158:96]
   output logic [159:0]                       rsp_tdata
);
   import wad_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_ACC, S_DEN, S_DIV} state_type;

   state_type              state_ff;
   logic [STEP_W-1:0]      step_ff;
   logic [CHANNELS-1:0]    en_ff;
   logic [STEP_W-1:0]      pos_ff;
   logic [STEP_W-1:0]      k_ff;
   logic [DEN_W-1:0]       den_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [TS_W-1:0]        ts_ff;
   logic [CHANNELS*VAL_W-1:0] val_ff;
   logic                   out_v_ff;
   logic [159:0]           out_d_ff;
   logic [STEP_W-1:0]      eff_step;
   logic [STEP_W-1:0]      k_cur;
   logic [2*STEP_W-1:0]    kk;
   lane_ctl_type           ctl;
   logic [CHANNELS*VAL_W-1:0] quots;
   logic                   div_done;
   logic                   emit;

   assign eff_step = (step_ff == '0) ? STEP_W'(1) :
                     (step_ff > STEP_W'(MAX_STEP)) ? STEP_W'(MAX_STEP) : step_ff;
   assign k_cur = pos_ff + STEP_W'(1);
   assign kk    = k_ff * (k_ff + STEP_W'(1));

   assign div_done = (state_ff == S_DIV) && (cnt_ff == CNT_W'(SUM_W));
   // hold until the previous beat has gone
   assign emit     = div_done && (!out_v_ff || rsp_tready);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

   always_comb begin
      ctl.acc       = (state_ff == S_ACC);
      ctl.clr       = 1'b0;
      ctl.div_start = (state_ff == S_DEN);
      ctl.div_step  = (state_ff == S_DIV) && !div_done;
      ctl.den       = den_ff;
   end

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      wad_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .enable (en_ff[c]),
         .value  (val_ff[c*VAL_W +: VAL_W]),
         .k      (k_ff),
         .quot   (quots[c*VAL_W +: VAL_W])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= STEP_W'(1);
         en_ff    <= '1;
         pos_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == REG_STEP) begin
            step_ff <= csr_wdata[STEP_W-1:0];
         end
         if (csr_we && csr_index == REG_ENABLE) begin
            en_ff <= csr_wdata[CHANNELS-1:0];
         end
         if (emit) begin
            out_d_ff <= {1'b0, ts_ff, quots};
            out_v_ff <= 1'b1;
         end else if (rsp_tvalid && rsp_tready) begin
            out_v_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  val_ff   <= req_tdata[CHANNELS*VAL_W-1:0];
                  ts_ff    <= req_tdata[96 +: TS_W];
                  k_ff     <= k_cur;
                  state_ff <= S_ACC;
               end
            end
            S_ACC: begin
               if (k_ff >= eff_step) begin
                  den_ff   <= kk[DEN_W:1];
                  pos_ff   <= '0;
                  state_ff <= S_DEN;
               end else begin
                  pos_ff   <= k_ff;
                  state_ff <= S_IDLE;
               end
            end
            S_DEN: begin
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  if (emit) begin
                     state_ff <= S_IDLE;
                  end
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- hw/rtl/wad_lane.sv -----
// One channel lane: weighted accumulator and bit-serial signed divider.
// Depends on wad_pkg.
module wad_lane (
   input  logic                        clock,
   input  logic                        reset,
   input  wad_pkg::lane_ctl_type       ctl,
   input  logic                        enable,
   input  logic [wad_pkg::VAL_W-1:0]   value,
   input  logic [wad_pkg::STEP_W-1:0]  k,
   output logic [wad_pkg::VAL_W-1:0]   quot
);
   import wad_pkg::*;

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [VAL_W+STEP_W:0] prod_n;
   logic signed [SUM_W-1:0] prod;
   logic [SUM_W-1:0]        q_ff, q_in;
   logic [DEN_W:0]          r_ff, r_in;
   logic                    neg_ff, neg_in;
   logic [DEN_W:0]          trial;
   logic [SUM_W-1:0]        mag;

   assign prod_n = $signed(value) * $signed({1'b0, k});
   assign prod   = {{(SUM_W-VAL_W-STEP_W-1){prod_n[VAL_W+STEP_W]}}, prod_n};
   assign mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign trial = {r_ff[DEN_W-1:0], q_ff[SUM_W-1]} - {1'b0, ctl.den};

   always_comb begin
      sum_in = sum_ff;
      q_in   = q_ff;
      r_in   = r_ff;
      neg_in = neg_ff;
      if (ctl.div_start) begin
         q_in   = enable ? mag : '0;
         r_in   = '0;
         neg_in = sum_ff[SUM_W-1];
         sum_in = '0;
      end else begin
         if (ctl.acc && enable) begin
            sum_in = sum_ff + prod;
         end
         // one restoring step per cycle; quotient held once done
         if (ctl.div_step) begin
            if (!trial[DEN_W]) begin
               r_in = trial;
               q_in = {q_ff[SUM_W-2:0], 1'b1};
            end else begin
               r_in = {r_ff[DEN_W-1:0], q_ff[SUM_W-1]};
               q_in = {q_ff[SUM_W-2:0], 1'b0};
            end
         end
      end
      if (ctl.clr) begin
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      neg_ff <= neg_in;
   end

   assign quot = neg_ff ? VAL_W'(-q_ff) : q_ff[VAL_W-1:0];
endmodule
